// File: design/positional_ordered_list_defines.svh
// assertion macros for the positional ordered list
`ifndef POSITIONAL_ORDERED_LIST_DEFINES_SVH
`define POSITIONAL_ORDERED_LIST_DEFINES_SVH

// same-cycle implication
`define POL_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define POL_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: design/pol_pkg.sv
// shared constants, codes and control types of the positional ordered list
package pol_pkg;

   localparam int CAPACITY = 16;
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int VALUE_W  = 32;
   localparam int POS_W    = 8;
   localparam int ACT_W    = 3;
   localparam int STAT_W   = 2;
   localparam int COUNT_W  = 7;

   typedef enum logic [ACT_W-1:0] {
      ACT_INS_HEAD = 3'd0,
      ACT_INS_TAIL = 3'd1,
      ACT_INS_AT   = 3'd2,
      ACT_DEL_HEAD = 3'd3,
      ACT_DEL_TAIL = 3'd4,
      ACT_DEL_AT   = 3'd5,
      ACT_READ     = 3'd6
   } action_type;

   typedef enum logic [STAT_W-1:0] {
      ST_OK     = 2'd0,
      ST_BADPOS = 2'd1,
      ST_FULL   = 2'd2,
      ST_EMPTY  = 2'd3
   } status_type;

   // controller to datapath
   typedef struct packed {
      logic exec;        // apply command, load its single result
      logic start_read;  // begin read out of a non-empty list
      logic emit;        // load next entry into the result register
   } ctrl_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic count_zero;
      logic idx_last;
   } dp_stat_type;

endpackage

// File: design/pol_ctrl.sv
// controller for the positional ordered list: handshakes and read-out sequencing
module pol_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [pol_pkg::ACT_W-1:0] req_action,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  pol_pkg::dp_stat_type  dp_stat,
   output pol_pkg::ctrl_cmd_type cmd
);

   typedef enum logic {
      S_IDLE,
      S_READ
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;
   logic      accept;
   logic      is_read;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE) && out_free;
   assign accept    = req_valid && req_ready;
   assign is_read   = (req_action == pol_pkg::ACT_READ);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd.exec       = accept && (!is_read || dp_stat.count_zero);
      cmd.start_read = accept && is_read && !dp_stat.count_zero;
      cmd.emit       = (state_ff == S_READ) && out_free;

      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (cmd.start_read) state_in = S_READ;
         end
         S_READ: begin
            if (cmd.emit && dp_stat.idx_last) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase

      priority if (cmd.exec || cmd.emit) rsp_valid_in = 1'b1;
      else if (rsp_ready)                 rsp_valid_in = 1'b0;
      else                                rsp_valid_in = rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// File: design/pol_dpath.sv
// datapath for the positional ordered list: entry cells, count and result register
module pol_dpath (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [pol_pkg::ACT_W-1:0]           req_action,
   input  logic signed [pol_pkg::VALUE_W-1:0]  req_item_value,
   input  logic [pol_pkg::POS_W-1:0]           req_position,
   input  pol_pkg::ctrl_cmd_type               cmd,
   output pol_pkg::dp_stat_type                dp_stat,
   output logic [pol_pkg::STAT_W-1:0]          rsp_status,
   output logic [pol_pkg::COUNT_W-1:0]         rsp_entry_count,
   output logic signed [pol_pkg::VALUE_W-1:0]  rsp_entry_value,
   output logic                                rsp_entry_valid,
   output logic                                rsp_last_result
);

   logic signed [pol_pkg::VALUE_W-1:0] cells_ff [pol_pkg::CAPACITY];
   logic signed [pol_pkg::VALUE_W-1:0] cells_in [pol_pkg::CAPACITY];
   logic signed [pol_pkg::VALUE_W-1:0] from_prev [pol_pkg::CAPACITY];
   logic signed [pol_pkg::VALUE_W-1:0] from_next [pol_pkg::CAPACITY];

   logic [pol_pkg::CNT_W-1:0]   count_ff, count_in;
   logic [pol_pkg::IDX_W-1:0]   idx_ff, idx_in;
   logic [pol_pkg::CNT_W-1:0]   slot;
   logic                        do_ins, do_del;
   logic                        full, empty;
   logic                        ins_pos_bad, del_pos_bad;
   pol_pkg::status_type         status;

   pol_pkg::status_type                status_ff, status_in;
   logic [pol_pkg::COUNT_W-1:0]        rcount_ff, rcount_in;
   logic signed [pol_pkg::VALUE_W-1:0] rvalue_ff, rvalue_in;
   logic                               rvalid_ff, rvalid_in;
   logic                               rlast_ff, rlast_in;

   // neighbor taps for shifting
   for (genvar g = 0; g < pol_pkg::CAPACITY; g++) begin : g_tap
      if (g == 0) begin : g_first
         assign from_prev[g] = req_item_value;
      end else begin : g_mid
         assign from_prev[g] = cells_ff[g-1];
      end
      if (g == pol_pkg::CAPACITY - 1) begin : g_lastcell
         assign from_next[g] = cells_ff[g];
      end else begin : g_body
         assign from_next[g] = cells_ff[g+1];
      end
   end

   assign full  = (count_ff == pol_pkg::CNT_W'(pol_pkg::CAPACITY));
   assign empty = (count_ff == '0);
   assign ins_pos_bad = (req_position == '0) ||
                        ({1'b0, req_position} > ((pol_pkg::POS_W+1)'(count_ff) +
                                                  (pol_pkg::POS_W+1)'(1)));
   assign del_pos_bad = (req_position == '0) ||
                        ({1'b0, req_position} > (pol_pkg::POS_W+1)'(count_ff));

   // command decode
   always_comb begin
      status = pol_pkg::ST_OK;
      do_ins = 1'b0;
      do_del = 1'b0;
      slot   = '0;
      unique case (req_action)
         pol_pkg::ACT_INS_HEAD: begin
            if (full) status = pol_pkg::ST_FULL;
            else      do_ins = 1'b1;
         end
         pol_pkg::ACT_INS_TAIL: begin
            slot = count_ff;
            if (full) status = pol_pkg::ST_FULL;
            else      do_ins = 1'b1;
         end
         pol_pkg::ACT_INS_AT: begin
            slot = pol_pkg::CNT_W'(req_position - pol_pkg::POS_W'(1));
            priority if (ins_pos_bad) status = pol_pkg::ST_BADPOS;
            else if (full)            status = pol_pkg::ST_FULL;
            else                      do_ins = 1'b1;
         end
         pol_pkg::ACT_DEL_HEAD: begin
            if (empty) status = pol_pkg::ST_EMPTY;
            else       do_del = 1'b1;
         end
         pol_pkg::ACT_DEL_TAIL: begin
            slot = count_ff - pol_pkg::CNT_W'(1);
            if (empty) status = pol_pkg::ST_EMPTY;
            else       do_del = 1'b1;
         end
         pol_pkg::ACT_DEL_AT: begin
            slot = pol_pkg::CNT_W'(req_position - pol_pkg::POS_W'(1));
            if (del_pos_bad) status = pol_pkg::ST_BADPOS;
            else             do_del = 1'b1;
         end
         pol_pkg::ACT_READ: begin
            status = pol_pkg::ST_EMPTY;
         end
         default: status = pol_pkg::ST_OK;
      endcase
   end

   // cell chain: every cell picks itself, a neighbor or the new value
   always_comb begin
      for (int i = 0; i < pol_pkg::CAPACITY; i++) begin
         cells_in[i] = cells_ff[i];
         if (cmd.exec && do_ins) begin
            if (pol_pkg::CNT_W'(i) == slot)     cells_in[i] = req_item_value;
            else if (pol_pkg::CNT_W'(i) > slot) cells_in[i] = from_prev[i];
         end else if (cmd.exec && do_del) begin
            if (pol_pkg::CNT_W'(i) >= slot)     cells_in[i] = from_next[i];
         end
      end
   end

   always_comb begin
      count_in = count_ff;
      if (cmd.exec && do_ins)      count_in = count_ff + pol_pkg::CNT_W'(1);
      else if (cmd.exec && do_del) count_in = count_ff - pol_pkg::CNT_W'(1);

      idx_in = idx_ff;
      if (cmd.start_read)  idx_in = '0;
      else if (cmd.emit)   idx_in = idx_ff + pol_pkg::IDX_W'(1);
   end

   assign dp_stat.count_zero = empty;
   assign dp_stat.idx_last   = ((pol_pkg::CNT_W'(idx_ff) + pol_pkg::CNT_W'(1)) == count_ff);

   // result register
   always_comb begin
      status_in = status_ff;
      rcount_in = rcount_ff;
      rvalue_in = rvalue_ff;
      rvalid_in = rvalid_ff;
      rlast_in  = rlast_ff;
      if (cmd.exec) begin
         status_in = status;
         rcount_in = pol_pkg::COUNT_W'(count_in);
         rvalue_in = '0;
         rvalid_in = 1'b0;
         rlast_in  = 1'b1;
      end else if (cmd.emit) begin
         status_in = pol_pkg::ST_OK;
         rcount_in = pol_pkg::COUNT_W'(count_ff);
         rvalue_in = cells_ff[idx_ff];
         rvalid_in = 1'b1;
         rlast_in  = dp_stat.idx_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         idx_ff   <= '0;
      end else begin
         count_ff <= count_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      cells_ff  <= cells_in;
      status_ff <= status_in;
      rcount_ff <= rcount_in;
      rvalue_ff <= rvalue_in;
      rvalid_ff <= rvalid_in;
      rlast_ff  <= rlast_in;
   end

   assign rsp_status      = status_ff;
   assign rsp_entry_count = rcount_ff;
   assign rsp_entry_value = rvalue_ff;
   assign rsp_entry_valid = rvalid_ff;
   assign rsp_last_result = rlast_ff;

endmodule

// File: design/positional_ordered_list.sv
// top level of the positional ordered list: controller, datapath and checks
//
//   channel  | direction | handshake            | payload
//   ---------+-----------+----------------------+---------------------------------------
//   req_     | in        | req_valid/req_ready  | action, item_value, position
//   rsp_     | out       | rsp_valid/rsp_ready  | status, entry_count, entry_value,
//            |           |                      | entry_valid, last_result
//
// for an insert, delete or no-op item, every cell picks its new value from
// itself or a neighbor in parallel, and the result lands in the output
// register at the same edge
// read out of a non-empty list first starts the walk, then presents the entries,
// head first, through the single read port into the cell chain; an empty list
// answers with a single result; no new item is taken meanwhile
// the output register stalls on rsp_ready; a new item is still taken in the
// cycle the waiting result leaves
// reset is synchronous; it empties the list and drops any pending result

`include "positional_ordered_list_defines.svh"

module positional_ordered_list (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [pol_pkg::ACT_W-1:0]           req_action,
   input  logic signed [pol_pkg::VALUE_W-1:0]  req_item_value,
   input  logic [pol_pkg::POS_W-1:0]           req_position,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [pol_pkg::STAT_W-1:0]          rsp_status,
   output logic [pol_pkg::COUNT_W-1:0]         rsp_entry_count,
   output logic signed [pol_pkg::VALUE_W-1:0]  rsp_entry_value,
   output logic                                rsp_entry_valid,
   output logic                                rsp_last_result
);

   // command and status between the two halves
   pol_pkg::ctrl_cmd_type cmd;
   pol_pkg::dp_stat_type  dp_stat;

   // sequencing: accept, result valid, read-out walk
   pol_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_action (req_action),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .dp_stat    (dp_stat),
      .cmd        (cmd)
   );

   // cell chain, count and result payload
   pol_dpath u_dpath (
      .clock           (clock),
      .reset           (reset),
      .req_action      (req_action),
      .req_item_value  (req_item_value),
      .req_position    (req_position),
      .cmd             (cmd),
      .dp_stat         (dp_stat),
      .rsp_status      (rsp_status),
      .rsp_entry_count (rsp_entry_count),
      .rsp_entry_value (rsp_entry_value),
      .rsp_entry_valid (rsp_entry_valid),
      .rsp_last_result (rsp_last_result)
   );

   // a non read-out item gives its single, final result right after acceptance
   `POL_ASSERT_NXT(a_single_result, clock, reset, req_valid && req_ready && (req_action != pol_pkg::ACT_READ), rsp_valid && rsp_last_result && !rsp_entry_valid, "single-result item missing its result")

   // an entry carried in a result always comes with ok status
   `POL_ASSERT_IMP(a_entry_ok, clock, reset, rsp_valid && rsp_entry_valid, rsp_status == pol_pkg::ST_OK, "entry result with non-ok status")

   // a result without an entry is always the final one of its item
   `POL_ASSERT_IMP(a_plain_last, clock, reset, rsp_valid && !rsp_entry_valid, rsp_last_result, "plain result not flagged last")

   // the reported count never exceeds the capacity
   `POL_ASSERT_IMP(a_count_cap, clock, reset, rsp_valid, rsp_entry_count <= pol_pkg::COUNT_W'(pol_pkg::CAPACITY), "count above capacity")

endmodule

// File: bench/tb_positional_ordered_list.sv
// self-checking bench for the positional ordered list: directed command rows, then random traffic
`timescale 1ns / 100ps

module tb_positional_ordered_list;

   // action code past the last command: the block answers with the count and changes nothing
   localparam logic [pol_pkg::ACT_W-1:0] ACT_NOP = 3'd7;

   localparam int RANDOM_ITEMS = 260;
   localparam int CALM_ITEMS   = 40;            // tail of the run with no idling on either side
   localparam int CYCLE_LIMIT  = 200000;
   localparam int DRAIN_CYCLES = pol_pkg::CAPACITY + 8;  // a read out can trail the last item
   localparam int REPORT_MAX   = 10;

   // one result item as the block should present it
   typedef struct {
      pol_pkg::status_type                 status;
      logic [pol_pkg::COUNT_W-1:0]         count;
      logic signed [pol_pkg::VALUE_W-1:0]  value;
      logic                                valid;
      logic                                last;
   } list_rsp_type;

   // one directed command; typed rows carry the single result read straight off the command
   typedef struct packed {
      logic [pol_pkg::ACT_W-1:0]    act;
      logic [pol_pkg::VALUE_W-1:0]  value;
      logic [pol_pkg::POS_W-1:0]    pos;
      logic                         typed;
      pol_pkg::status_type          status;
      logic [pol_pkg::COUNT_W-1:0]  count;
   } cmd_row_type;

   logic                                clock = 1'b0;
   logic                                reset;
   logic                                req_valid;
   logic                                req_ready;
   logic [pol_pkg::ACT_W-1:0]           req_action;
   logic signed [pol_pkg::VALUE_W-1:0]  req_item_value;
   logic [pol_pkg::POS_W-1:0]           req_position;
   logic                                rsp_valid;
   logic                                rsp_ready;
   logic [pol_pkg::STAT_W-1:0]          rsp_status;
   logic [pol_pkg::COUNT_W-1:0]         rsp_entry_count;
   logic signed [pol_pkg::VALUE_W-1:0]  rsp_entry_value;
   logic                                rsp_entry_valid;
   logic                                rsp_last_result;

   // shadow copy of the list, head at index 0
   logic signed [pol_pkg::VALUE_W-1:0] held_entries[$];
   // results still owed by the block, oldest first
   list_rsp_type owed_results[$];

   bit calm = 1'b0;
   int cycles = 0;
   int mismatches = 0;
   int results_checked = 0;
   int commands_sent = 0;
   int read_outs = 0;
   int peak_length = 0;
   int status_seen [4] = '{0, 0, 0, 0};

   // empty-list errors, position errors on both sides, extreme values, no-op with all bits set
   cmd_row_type directed_cmds [23] = '{
      '{pol_pkg::ACT_READ,     32'h0000_0000, 8'd0,   1'b1, pol_pkg::ST_EMPTY,  7'd0},
      '{pol_pkg::ACT_DEL_HEAD, 32'h0000_0000, 8'd0,   1'b1, pol_pkg::ST_EMPTY,  7'd0},
      '{pol_pkg::ACT_DEL_TAIL, 32'hFFFF_FFFF, 8'd255, 1'b1, pol_pkg::ST_EMPTY,  7'd0},
      '{pol_pkg::ACT_DEL_AT,   32'h0000_0000, 8'd1,   1'b1, pol_pkg::ST_BADPOS, 7'd0},
      '{pol_pkg::ACT_INS_AT,   32'h0000_0005, 8'd0,   1'b1, pol_pkg::ST_BADPOS, 7'd0},
      '{pol_pkg::ACT_INS_AT,   32'h0000_0005, 8'd2,   1'b1, pol_pkg::ST_BADPOS, 7'd0},
      '{pol_pkg::ACT_INS_HEAD, 32'h7FFF_FFFF, 8'd0,   1'b1, pol_pkg::ST_OK,     7'd1},
      '{pol_pkg::ACT_INS_TAIL, 32'h8000_0000, 8'd255, 1'b1, pol_pkg::ST_OK,     7'd2},
      '{pol_pkg::ACT_INS_AT,   32'hFFFF_FFFF, 8'd2,   1'b1, pol_pkg::ST_OK,     7'd3},
      '{ACT_NOP,               32'hFFFF_FFFF, 8'd255, 1'b1, pol_pkg::ST_OK,     7'd3},
      '{pol_pkg::ACT_READ,     32'h0000_0000, 8'd0,   1'b0, pol_pkg::ST_OK,     7'd0},
      '{pol_pkg::ACT_INS_AT,   32'h0000_0009, 8'd5,   1'b1, pol_pkg::ST_BADPOS, 7'd3},
      '{pol_pkg::ACT_INS_AT,   32'h0000_0001, 8'd4,   1'b1, pol_pkg::ST_OK,     7'd4},
      '{pol_pkg::ACT_DEL_AT,   32'h0000_0000, 8'd0,   1'b1, pol_pkg::ST_BADPOS, 7'd4},
      '{pol_pkg::ACT_DEL_AT,   32'h0000_0000, 8'd5,   1'b1, pol_pkg::ST_BADPOS, 7'd4},
      '{pol_pkg::ACT_DEL_AT,   32'h0000_0000, 8'd255, 1'b1, pol_pkg::ST_BADPOS, 7'd4},
      '{pol_pkg::ACT_DEL_AT,   32'h0000_0000, 8'd2,   1'b1, pol_pkg::ST_OK,     7'd3},
      '{pol_pkg::ACT_READ,     32'h0000_0000, 8'd0,   1'b0, pol_pkg::ST_OK,     7'd0},
      '{pol_pkg::ACT_DEL_HEAD, 32'h0000_0000, 8'd0,   1'b1, pol_pkg::ST_OK,     7'd2},
      '{pol_pkg::ACT_DEL_TAIL, 32'h0000_0000, 8'd0,   1'b1, pol_pkg::ST_OK,     7'd1},
      '{pol_pkg::ACT_DEL_AT,   32'h0000_0000, 8'd1,   1'b1, pol_pkg::ST_OK,     7'd0},
      '{pol_pkg::ACT_INS_AT,   32'h0000_0000, 8'd1,   1'b1, pol_pkg::ST_OK,     7'd1},
      '{pol_pkg::ACT_READ,     32'h0000_0000, 8'd0,   1'b0, pol_pkg::ST_OK,     7'd0}
   };

   positional_ordered_list dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_action      (req_action),
      .req_item_value  (req_item_value),
      .req_position    (req_position),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_status      (rsp_status),
      .rsp_entry_count (rsp_entry_count),
      .rsp_entry_value (rsp_entry_value),
      .rsp_entry_valid (rsp_entry_valid),
      .rsp_last_result (rsp_last_result)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // queue one owed result; the count is the list length after the command
   function automatic void owe_result(pol_pkg::status_type st,
                                      logic signed [pol_pkg::VALUE_W-1:0] v,
                                      logic vld, logic lst);
      list_rsp_type r;
      r.status = st;
      r.count  = pol_pkg::COUNT_W'(held_entries.size());
      r.value  = v;
      r.valid  = vld;
      r.last   = lst;
      owed_results.push_back(r);
   endfunction

   // apply one accepted command to the shadow list and queue what the block must answer
   task automatic apply_list_command(input logic [pol_pkg::ACT_W-1:0] act,
                                     input logic signed [pol_pkg::VALUE_W-1:0] val,
                                     input logic [pol_pkg::POS_W-1:0] pos);
      pol_pkg::status_type st;
      int n;
      int p;
      st = pol_pkg::ST_OK;
      n = held_entries.size();
      p = int'(pos);
      case (act)
         pol_pkg::ACT_INS_HEAD, pol_pkg::ACT_INS_TAIL: begin
            if (n >= pol_pkg::CAPACITY) st = pol_pkg::ST_FULL;
            else if (act == pol_pkg::ACT_INS_HEAD) held_entries.push_front(val);
            else held_entries.push_back(val);
         end
         pol_pkg::ACT_INS_AT: begin
            // a bad position wins over a full list
            if (p < 1 || p > n + 1) st = pol_pkg::ST_BADPOS;
            else if (n >= pol_pkg::CAPACITY) st = pol_pkg::ST_FULL;
            else held_entries.insert(p - 1, val);
         end
         pol_pkg::ACT_DEL_HEAD, pol_pkg::ACT_DEL_TAIL: begin
            if (n == 0) st = pol_pkg::ST_EMPTY;
            else if (act == pol_pkg::ACT_DEL_HEAD) void'(held_entries.pop_front());
            else void'(held_entries.pop_back());
         end
         pol_pkg::ACT_DEL_AT: begin
            if (p < 1 || p > n) st = pol_pkg::ST_BADPOS;
            else held_entries.delete(p - 1);
         end
         pol_pkg::ACT_READ: begin
            read_outs++;
            if (n == 0) begin
               status_seen[pol_pkg::ST_EMPTY]++;
               owe_result(pol_pkg::ST_EMPTY, '0, 1'b0, 1'b1);
            end else begin
               status_seen[pol_pkg::ST_OK]++;
               for (int i = 0; i < n; i++)
                  owe_result(pol_pkg::ST_OK, held_entries[i], 1'b1, i == n - 1);
            end
            return;
         end
         default: ;  // no-op code
      endcase
      if (held_entries.size() > peak_length) peak_length = held_entries.size();
      status_seen[st]++;
      owe_result(st, '0, 1'b0, 1'b1);
   endtask

   // present one item and hold it until the block takes it; optional idle burst first
   task automatic send_list_command(input logic [pol_pkg::ACT_W-1:0] act,
                                    input logic signed [pol_pkg::VALUE_W-1:0] val,
                                    input logic [pol_pkg::POS_W-1:0] pos,
                                    input bit allow_gap);
      if (allow_gap && $urandom_range(0, 99) < 30) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_action     <= act;
      req_item_value <= val;
      req_position   <= pos;
      @(posedge clock);
      while (req_ready !== 1'b1) @(posedge clock);
      // taken at this edge
      commands_sent++;
      apply_list_command(act, val, pos);
   endtask

   // item values lean on the extremes now and then
   function automatic logic signed [pol_pkg::VALUE_W-1:0] pick_item_value();
      case ($urandom_range(0, 9))
         0:       return 32'sh7FFF_FFFF;
         1:       return 32'sh8000_0000;
         2:       return '0;
         3:       return -32'sd1;
         default: return $signed($urandom);
      endcase
   endfunction

   // random command; growing phases favor inserts, shrinking phases favor deletes
   task automatic send_random_command(input bit grow, input bit allow_gap);
      logic [pol_pkg::ACT_W-1:0] act;
      logic [pol_pkg::POS_W-1:0] pos;
      int r;
      int n;
      n = held_entries.size();
      r = $urandom_range(0, 99);
      if (grow) begin
         if (r < 25)      act = pol_pkg::ACT_INS_HEAD;
         else if (r < 50) act = pol_pkg::ACT_INS_TAIL;
         else if (r < 72) act = pol_pkg::ACT_INS_AT;
         else if (r < 77) act = pol_pkg::ACT_DEL_HEAD;
         else if (r < 82) act = pol_pkg::ACT_DEL_TAIL;
         else if (r < 88) act = pol_pkg::ACT_DEL_AT;
         else if (r < 96) act = pol_pkg::ACT_READ;
         else             act = ACT_NOP;
      end else begin
         if (r < 8)       act = pol_pkg::ACT_INS_HEAD;
         else if (r < 16) act = pol_pkg::ACT_INS_TAIL;
         else if (r < 24) act = pol_pkg::ACT_INS_AT;
         else if (r < 44) act = pol_pkg::ACT_DEL_HEAD;
         else if (r < 64) act = pol_pkg::ACT_DEL_TAIL;
         else if (r < 88) act = pol_pkg::ACT_DEL_AT;
         else if (r < 96) act = pol_pkg::ACT_READ;
         else             act = ACT_NOP;
      end
      // mostly legal positions, the rest anywhere in the field
      pos = pol_pkg::POS_W'($urandom_range(0, 255));
      if (act == pol_pkg::ACT_INS_AT && $urandom_range(0, 99) < 85)
         pos = pol_pkg::POS_W'($urandom_range(1, n + 1));
      else if (act == pol_pkg::ACT_DEL_AT && n > 0 && $urandom_range(0, 99) < 85)
         pos = pol_pkg::POS_W'($urandom_range(1, n));
      // on a full list, aim just past the end: full at count+1, bad position at count+2
      if (act == pol_pkg::ACT_INS_AT && n == pol_pkg::CAPACITY && $urandom_range(0, 2) == 0)
         pos = pol_pkg::POS_W'(n + 1 + int'($urandom_range(0, 1)));
      send_list_command(act, pick_item_value(), pos, allow_gap);
   endtask

   task automatic note_mismatch(input string what, input list_rsp_type want);
      mismatches++;
      if (mismatches <= REPORT_MAX) begin
         $display("mismatch at cycle %0d, %s", cycles, what);
         $display("  expected status %0d count %0d value %0d valid %0d last %0d",
                  want.status, want.count, want.value, want.valid, want.last);
         $display("  actual   status %0d count %0d value %0d valid %0d last %0d",
                  rsp_status, rsp_entry_count, rsp_entry_value, rsp_entry_valid,
                  rsp_last_result);
      end
   endtask

   // result checker: compare each accepted result with the oldest owed one
   always @(posedge clock) begin
      list_rsp_type want;
      if (reset === 1'b0 && rsp_valid === 1'b1 && rsp_ready === 1'b1) begin
         results_checked++;
         if (owed_results.size() == 0) begin
            want = '{pol_pkg::ST_OK, '0, '0, 1'b0, 1'b0};
            note_mismatch("result with nothing expected", want);
         end else begin
            want = owed_results.pop_front();
            if (rsp_status !== want.status || rsp_entry_count !== want.count ||
                rsp_entry_value !== want.value || rsp_entry_valid !== want.valid ||
                rsp_last_result !== want.last)
               note_mismatch("field mismatch", want);
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("timeout at cycle %0d with %0d results outstanding",
                  cycles, owed_results.size());
         $display("TEST FAILED");
         $finish;
      end
   end

   // result side: random stall bursts, steady ready in the calm tail
   initial begin
      rsp_ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (calm) begin
            rsp_ready <= 1'b1;
            @(posedge clock);
         end else if ($urandom_range(0, 99) < 30) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clock);
         end else begin
            rsp_ready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end
      end
   end

   // command side: reset, directed rows, random phases, drain and verdict
   initial begin
      list_rsp_type typed_rsp;
      bit grow;
      int phase_left;
      reset          <= 1'b1;
      req_valid      <= 1'b0;
      req_action     <= ACT_NOP;
      req_item_value <= '0;
      req_position   <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed part; typed rows replace the predicted single result with the spelled-out one
      foreach (directed_cmds[i]) begin
         send_list_command(directed_cmds[i].act, directed_cmds[i].value,
                           directed_cmds[i].pos, 1'b1);
         if (directed_cmds[i].typed) begin
            typed_rsp        = owed_results.pop_back();
            typed_rsp.status = directed_cmds[i].status;
            typed_rsp.count  = directed_cmds[i].count;
            typed_rsp.value  = '0;
            typed_rsp.valid  = 1'b0;
            typed_rsp.last   = 1'b1;
            owed_results.push_back(typed_rsp);
         end
      end

      // random part in alternating grow and shrink phases so the list runs full and empty
      grow = 1'b1;
      phase_left = $urandom_range(30, 45);
      for (int k = 0; k < RANDOM_ITEMS; k++) begin
         if (k == RANDOM_ITEMS - CALM_ITEMS) calm = 1'b1;
         if (phase_left == 0) begin
            grow = !grow;
            phase_left = $urandom_range(20, 45);
         end
         phase_left--;
         send_random_command(grow, !calm);
      end
      req_valid <= 1'b0;

      // let every owed result arrive, then watch a little longer for strays
      while (owed_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("%0d commands (%0d read outs), %0d results checked, longest list %0d of %0d",
               commands_sent, read_outs, results_checked, peak_length, pol_pkg::CAPACITY);
      $display("status counts: ok %0d, bad position %0d, full %0d, empty %0d; mismatches %0d",
               status_seen[pol_pkg::ST_OK], status_seen[pol_pkg::ST_BADPOS],
               status_seen[pol_pkg::ST_FULL], status_seen[pol_pkg::ST_EMPTY], mismatches);
      if (mismatches == 0 && owed_results.size() == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
